[rtl/fnv_pkg.sv]
// Shared constants and helpers for the multi-width FNV-1a hasher.
// Holds the width mode codes, offset bases and prime terms.
// No dependencies.
package fnv_pkg;

    typedef enum logic [2:0] {
        MODE_W32   = 3'd0,
        MODE_W64   = 3'd1,
        MODE_W128  = 3'd2,
        MODE_W256  = 3'd3,
        MODE_W512  = 3'd4,
        MODE_W1024 = 3'd5
    } t_width_mode;

    localparam int NUM_WIDTHS     = 6;
    localparam int MAX_HASH_BITS  = 1024;
    localparam int WORD_BITS      = 64;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 3;

    // Register index of the width selector.
    localparam logic REG_WIDTH_MODE = 1'b0;

    // Each prime is 2^shift + 2^8 + low, with low below 2^8.
    localparam int PRIME_SHIFT [NUM_WIDTHS] = '{24, 40, 88, 168, 344, 680};
    localparam logic [7:0] PRIME_LOW [NUM_WIDTHS] = '{
        8'h93, 8'hb3, 8'h3b, 8'h63, 8'h57, 8'h8d
    };

    localparam logic [1023:0] BASIS [NUM_WIDTHS] = '{
        1024'h811c9dc5,
        1024'hcbf29ce484222325,
        1024'({64'h6c62272e07bb0142, 64'h62b821756295c58d}),
        1024'({64'hdd268dbcaac55036, 64'h2d98c384c4e576cc,
               64'hc8b1536847b6bbb3, 64'h1023b4c8caee0535}),
        1024'({64'hb86db0b1171f4416, 64'hdca1e50f309990ac,
               64'hac87d059c9000000, 64'h0000000000000d21,
               64'he948f68a34c192f6, 64'h2ea79bc942dbe7ce,
               64'h182036415f56e34b, 64'hac982aac4afe9fd9}),
        {64'h0000000000000000, 64'h005f7a76758ecc4d,
         64'h32e56d5a591028b7, 64'h4b29fc4223fdada1,
         64'h6c3bf34eda3674da, 64'h9a21d90000000000,
         64'h0000000000000000, 64'h0000000000000000,
         64'h0000000000000000, 64'h0000000000000000,
         64'h0000000000000000, 64'h000000000004c6d7,
         64'heb6e73802734510a, 64'h555f256cc005ae55,
         64'h6bde8cc9c6a93b21, 64'haff4b16c71ee90b3}
    };

    function automatic int mode_bits(input int m);
        return 32 << m;
    endfunction

    function automatic int mode_limbs(input int m);
        return (mode_bits(m) > WORD_BITS) ? mode_bits(m) / WORD_BITS : 1;
    endfunction

    // Largest mode whose width does not exceed the given bit count.
    function automatic int fit_mode(input int max_bits);
        int m;
        m = 0;
        for (int i = 1; i < NUM_WIDTHS; i++) begin
            if (mode_bits(i) <= max_bits) m = i;
        end
        return m;
    endfunction

endpackage

[rtl/fnv1a_hash_multiwidth_top.sv]
// Top level of the multi-width FNV-1a byte-stream hasher.
// Stream input of bytes, stream output of 64-bit digest words, APB config.
// Depends on fnv_pkg.
//
//  Channel   Direction  Payload                                 Transaction
//  s_axis    in         tdata[7:0] data_byte, tuser[0] has_byte, tvalid & tready
//                       tuser[1] start_req, tlast last
//  m_axis    out        tdata[63:0] digest_word, tlast last_word tvalid & tready
//  apb       in         pwdata[2:0] width_mode at paddr 0         psel & penable & pwrite
//
// One byte is absorbed per cycle while s_axis_tready is high: the XOR and the
// constant shift-add multiply over the full hash width sit between the hash
// register and itself. A digest leaves as 64-bit words (1 to 16 words) from a
// snapshot register; while it drains, items without tlast keep flowing and an
// item with tlast waits until the final word leaves. Reset is synchronous and
// clears the hash, the control flags and sets the width to 64 bits.
module fnv1a_hash_multiwidth_top #(
    parameter int MAX_HASH_BITS = fnv_pkg::MAX_HASH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // fields: [7:0] data_byte
    input  logic [7:0]  s_axis_tdata,
    // fields: [0] has_byte, [1] start_req
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // fields: [63:0] digest_word
    output logic [fnv_pkg::WORD_BITS-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [fnv_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [fnv_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [fnv_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic        pready
);

    localparam int MaxMode  = fnv_pkg::fit_mode(MAX_HASH_BITS);
    localparam int NumModes = MaxMode + 1;
    localparam int HashW    = fnv_pkg::mode_bits(MaxMode);
    localparam int Limbs    = fnv_pkg::mode_limbs(MaxMode);
    localparam int DigW     = Limbs * fnv_pkg::WORD_BITS;
    localparam int IdxW     = (Limbs > 1) ? $clog2(Limbs) : 1;

    logic [2:0]        r_width_mode;
    logic [HashW-1:0]  r_hash, n_hash;
    logic [DigW-1:0]   r_dig;
    logic [IdxW-1:0]   r_idx, n_idx;
    logic              r_busy, n_busy;

    logic [2:0]        w_mode;
    logic [HashW-1:0]  w_prod  [NumModes];
    logic [HashW-1:0]  w_basis [NumModes];
    logic [HashW-1:0]  w_mask  [NumModes];
    logic [HashW-1:0]  w_prod_sel, w_basis_sel, w_mask_sel, w_base;
    logic [IdxW-1:0]   w_idx_load;
    logic              w_in_acc, w_out_acc, w_finish, w_cfg_wr;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == fnv_pkg::REG_WIDTH_MODE);
    assign prdata   = (paddr[2] == fnv_pkg::REG_WIDTH_MODE)
                      ? {{(fnv_pkg::CFG_DATA_BITS - 3){1'b0}}, r_width_mode}
                      : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode <= 3'(fnv_pkg::MODE_W64);
        end else if (w_cfg_wr) begin
            r_width_mode <= pwdata[2:0];
        end
    end

    // Codes above the widest width act as the widest width that is built.
    always_comb begin
        w_mode = (r_width_mode > 3'(fnv_pkg::MODE_W1024))
                 ? 3'(fnv_pkg::MODE_W1024) : r_width_mode;
        if (w_mode > 3'(MaxMode)) w_mode = 3'(MaxMode);
    end

    // One datapath per width; every shift and coefficient is a constant.
    for (genvar g = 0; g < NumModes; g++) begin : g_mode
        localparam int Wm = fnv_pkg::mode_bits(g);
        localparam int Sm = fnv_pkg::PRIME_SHIFT[g];
        localparam logic [7:0] Cm = fnv_pkg::PRIME_LOW[g];
        logic [Wm-1:0] w_x, w_p;

        assign w_x = w_base[Wm-1:0] ^ Wm'(s_axis_tdata);
        assign w_p = (w_x << Sm) + (w_x << 8) + (w_x * Wm'(Cm));
        assign w_prod[g]  = HashW'(w_p);
        assign w_basis[g] = fnv_pkg::BASIS[g][HashW-1:0];
        assign w_mask[g]  = HashW'({Wm{1'b1}});
    end

    always_comb begin
        w_prod_sel  = w_prod[0];
        w_basis_sel = w_basis[0];
        w_mask_sel  = w_mask[0];
        w_idx_load  = '0;
        for (int m = 0; m < NumModes; m++) begin
            if (w_mode == 3'(m)) begin
                w_prod_sel  = w_prod[m];
                w_basis_sel = w_basis[m];
                w_mask_sel  = w_mask[m];
                w_idx_load  = IdxW'(fnv_pkg::mode_limbs(m) - 1);
            end
        end
    end

    // Handshakes. Only an item that closes a digest (tlast) waits for the last word.
    assign w_out_acc     = r_busy && m_axis_tready;
    assign w_finish      = w_out_acc && (r_idx == '0);
    assign s_axis_tready = !r_busy || w_finish || !s_axis_tlast;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_base = s_axis_tuser[1] ? w_basis_sel : r_hash;

    always_comb begin
        n_hash = r_hash;
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_in_acc) begin
            n_hash = s_axis_tuser[0] ? w_prod_sel : w_base;
        end
        if (w_in_acc && s_axis_tlast) begin
            n_busy = 1'b1;
            n_idx  = w_idx_load;
        end else if (w_finish) begin
            n_busy = 1'b0;
        end else if (w_out_acc) begin
            n_idx = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_hash <= n_hash;
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // Digest snapshot, masked to the active width.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tlast) begin
            r_dig <= DigW'(n_hash & w_mask_sel);
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = r_dig[r_idx * fnv_pkg::WORD_BITS +: fnv_pkg::WORD_BITS];
    assign m_axis_tlast  = (r_idx == '0);

endmodule

[tb/testbench.sv]
// Self-checking testbench for fnv1a_hash_multiwidth_top: byte stream in, digest words out.
// Holds its own bit-level model of the FNV-1a hasher in every width and checks each word.
// Depends on fnv_pkg and the top level of the hasher.
`timescale 1ns / 100ps

module testbench;

    // Width selector codes beyond the legal range; the block treats both as 1024 bits.
    localparam logic [2:0] MODE_OVER_6 = 3'd6;
    localparam logic [2:0] MODE_OVER_7 = 3'd7;
    localparam int CFG_AW = fnv_pkg::CFG_ADDR_BITS;
    localparam logic [CFG_AW-1:0] WIDTH_ADDR = CFG_AW'(4 * fnv_pkg::REG_WIDTH_MODE);
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       start;
        logic       last;
        logic       drain_first;
    } t_byte_item;

    typedef struct {
        logic [63:0] word;
        logic        fin;
    } t_digest_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // fields: [7:0] data_byte
    logic [7:0]  s_axis_tdata = '0;
    // fields: [0] has_byte, [1] start_req
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // fields: [63:0] digest_word
    logic [fnv_pkg::WORD_BITS-1:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [fnv_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [fnv_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [fnv_pkg::CFG_DATA_BITS-1:0] prdata;
    logic        pready;

    t_byte_item   byte_q[$];
    t_digest_word digest_q[$];
    t_byte_item   next_item;
    t_digest_word want;

    // Model state: running hash and width register.
    logic [1023:0] run_hash = '0;
    logic [2:0]    width_reg = fnv_pkg::MODE_W64;

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  sent_cnt = 0;
    int  src_gap = 0;
    int  sink_wait = 0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;

    fnv1a_hash_multiwidth_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [1023:0] offset_basis_of(input fnv_pkg::t_width_mode m);
        case (m)
            fnv_pkg::MODE_W32:  return 1024'h811c9dc5;
            fnv_pkg::MODE_W64:  return 1024'hcbf29ce484222325;
            fnv_pkg::MODE_W128: return {64'h6c62272e07bb0142, 64'h62b821756295c58d};
            fnv_pkg::MODE_W256: return {64'hdd268dbcaac55036, 64'h2d98c384c4e576cc,
                                        64'hc8b1536847b6bbb3, 64'h1023b4c8caee0535};
            fnv_pkg::MODE_W512: return {64'hb86db0b1171f4416, 64'hdca1e50f309990ac,
                                        64'hac87d059c9000000, 64'h0000000000000d21,
                                        64'he948f68a34c192f6, 64'h2ea79bc942dbe7ce,
                                        64'h182036415f56e34b, 64'hac982aac4afe9fd9};
            default:            return {64'h0, 64'h005f7a76758ecc4d,
                                        64'h32e56d5a591028b7, 64'h4b29fc4223fdada1,
                                        64'h6c3bf34eda3674da, 64'h9a21d90000000000,
                                        64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
                                        64'h000000000004c6d7, 64'heb6e73802734510a,
                                        64'h555f256cc005ae55, 64'h6bde8cc9c6a93b21,
                                        64'haff4b16c71ee90b3};
        endcase
    endfunction

    // Applies one accepted transaction to the running hash and queues the digest words.
    task automatic fnv_absorb_item(input logic [7:0] data, input logic has_byte,
                                   input logic start, input logic last);
        fnv_pkg::t_width_mode eff;
        int            nbits;
        int            nlimbs;
        int            pshift;
        int            limb;
        logic [1023:0] msk;
        logic [1023:0] w;
        logic [1023:0] plow;
        t_digest_word  dw;
        eff = (width_reg > fnv_pkg::MODE_W1024) ? fnv_pkg::MODE_W1024
                                                : fnv_pkg::t_width_mode'(width_reg);
        nbits = 32 << eff;
        nlimbs = (nbits > 64) ? nbits / 64 : 1;
        msk = '1;
        if (nbits < 1024) msk = (1024'd1 << nbits) - 1'b1;
        case (eff)
            fnv_pkg::MODE_W32:  begin pshift = 24;  plow = 1024'h93; end
            fnv_pkg::MODE_W64:  begin pshift = 40;  plow = 1024'hb3; end
            fnv_pkg::MODE_W128: begin pshift = 88;  plow = 1024'h3b; end
            fnv_pkg::MODE_W256: begin pshift = 168; plow = 1024'h63; end
            fnv_pkg::MODE_W512: begin pshift = 344; plow = 1024'h57; end
            default:            begin pshift = 680; plow = 1024'h8d; end
        endcase
        if (start) run_hash = offset_basis_of(eff) & msk;
        if (has_byte) begin
            // Multiply by 2^shift + 2^8 + low, modulo 2^width.
            w = (run_hash & msk) ^ {1016'd0, data};
            run_hash = ((w << pshift) + (w << 8) + w * plow) & msk;
        end
        if (last) begin
            for (int k = 0; k < nlimbs; k++) begin
                limb = nlimbs - 1 - k;
                dw.word = run_hash[limb*64 +: 64] & msk[limb*64 +: 64];
                dw.fin = (k == nlimbs - 1);
                digest_q.push_back(dw);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch in %s: expected %h, got %h at cycle %0d",
                     what, exp_v, act_v, cycle_cnt);
    endtask

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Sampling side: acceptance flags, prediction, checking and the watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && psel && penable && pready) begin
            if (pwrite) begin
                width_reg = pwdata[2:0];
            end else if (prdata !== 32'(width_reg)) begin
                note_mismatch("width_mode readback", 64'(width_reg), 64'(prdata));
            end
        end
        if (in_fire)
            fnv_absorb_item(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1], s_axis_tlast);
        if (out_fire) begin
            if (digest_q.size() == 0) begin
                note_mismatch("unexpected digest transaction", 64'd0, m_axis_tdata);
            end else begin
                want = digest_q.pop_front();
                if (m_axis_tdata !== want.word)
                    note_mismatch("digest_word", want.word, m_axis_tdata);
                if (m_axis_tlast !== want.fin)
                    note_mismatch("last_word", 64'(want.fin), 64'(m_axis_tlast));
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Byte stream driver.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (byte_q.size() == 0 ||
                         (byte_q[0].drain_first && digest_q.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                next_item = byte_q.pop_front();
                s_axis_tdata <= next_item.data;
                s_axis_tuser <= {next_item.start, next_item.has_byte};
                s_axis_tlast <= next_item.last;
                s_axis_tvalid <= 1'b1;
                sent_cnt++;
                src_gap = draw_wait((sent_cnt / 20) % 3 == 2);
            end
        end
    end

    // Digest sink with random back-pressure, calm in some stretches.
    always @(negedge i_clk) begin
        if (out_fire) sink_wait = draw_wait((cycle_cnt / 1024) % 3 == 1);
        if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void add_item(input logic [7:0] data, input logic has_byte,
                                     input logic start, input logic last,
                                     input logic drain_first);
        t_byte_item it;
        it.data = data;
        it.has_byte = has_byte;
        it.start = start;
        it.last = last;
        it.drain_first = drain_first;
        byte_q.push_back(it);
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_q.size() != 0 || s_axis_tvalid || digest_q.size() != 0);
        // Items without a digest leave no words to wait for; let the block settle.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the width register, then reads it back.
    task automatic set_width(input logic [2:0] sel);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= WIDTH_ADDR;
        pwdata <= 32'(sel);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_phase(input logic [2:0] sel, input int count);
        int         made;
        int         len;
        int         pick;
        logic [2:0] flags;
        set_width(sel);
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // Well-formed message: start on the first byte, last on the final one.
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    add_item(8'($urandom_range(0, 255)), 1'b1, i == 0, i == len - 1, 1'b0);
                made += len;
            end else if (pick == 7) begin
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0);
            end else begin
                flags = 3'($urandom_range(0, 7));
                add_item(8'($urandom_range(0, 255)), flags[0], flags[1], flags[2], pick == 9);
                if (flags != 3'b000) made++;
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width is 64 bits; the hash starts from zero without a start mark.
        add_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
        add_item(8'h61, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h80, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'h3c, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(8'h55, 1'b0, 1'b0, 1'b1, 1'b0);
        add_item(8'haa, 1'b1, 1'b1, 1'b1, 1'b1);
        wait_idle();

        set_width(MODE_OVER_7);
        add_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0, 1'b1, 1'b0);
        wait_idle();
        set_width(MODE_OVER_6);
        add_item(8'h7f, 1'b1, 1'b1, 1'b1, 1'b0);
        add_item(8'hc3, 1'b0, 1'b0, 1'b1, 1'b0);
        wait_idle();

        // Narrowing and then widening the hash in the middle of a message.
        set_width(fnv_pkg::MODE_W32);
        add_item(8'h01, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'hfe, 1'b1, 1'b1, 1'b1, 1'b0);
        wait_idle();
        set_width(fnv_pkg::MODE_W1024);
        add_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        add_item(8'h10, 1'b1, 1'b0, 1'b1, 1'b0);
        wait_idle();
        set_width(fnv_pkg::MODE_W128);
        add_item(8'h31, 1'b1, 1'b1, 1'b1, 1'b0);
        wait_idle();
        set_width(fnv_pkg::MODE_W256);
        add_item(8'h32, 1'b1, 1'b1, 1'b1, 1'b0);
        wait_idle();
        set_width(fnv_pkg::MODE_W512);
        add_item(8'h33, 1'b1, 1'b1, 1'b1, 1'b0);
        wait_idle();

        random_phase(fnv_pkg::MODE_W32, 12);
        random_phase(fnv_pkg::MODE_W1024, 12);
        random_phase(MODE_OVER_7, 12);
        random_phase(fnv_pkg::MODE_W64, 12);
        random_phase(fnv_pkg::MODE_W256, 12);
        random_phase(MODE_OVER_6, 12);
        random_phase(fnv_pkg::MODE_W128, 12);
        random_phase(fnv_pkg::MODE_W512, 12);
        random_phase(fnv_pkg::MODE_W32, 12);
        random_phase(fnv_pkg::MODE_W1024, 12);

        err_cnt += digest_q.size();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
